// ===== rtl/tsps_pkg.sv =====
// Package for the touch sensor poll sequencer: codes, state and record types.
// Used by tsps_ctrl and the top level in rtl/. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsps_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSE       = 1'd1;

    // Input action codes
    localparam logic [1:0] ACT_START     = 2'd0;
    localparam logic [1:0] ACT_XFER_DONE = 2'd1;
    localparam logic [1:0] ACT_LOAD      = 2'd2;

    localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
    localparam logic [7:0] SENSE_RESET       = 8'h00;

    // One mapping entry as stored in the table memory
    typedef struct packed {
        logic [4:0] second_pixel;
        logic [4:0] first_pixel;
        logic [6:0] address;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result record
    typedef struct packed {
        logic        command_valid;
        logic [6:0]  command_address;
        logic        command_is_read;
        logic [7:0]  command_byte;
        logic        scan_done;
        logic [31:0] touch_bitmap;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK_RD,
        ST_SEEK_CHK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/tsps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tsps_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tsps_ctrl.sv =====
// Scan sequencer: configuration registers, scan state, table walk and result build.
// Depends on tsps_pkg; drives the table RAM ports instantiated in the top level.
`timescale 1ns / 1ps
`default_nettype none

module tsps_ctrl #(
    parameter int NUM_DEVICES = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tsps_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [tsps_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input items
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [1:0]                             action,
    input  wire logic [3:0]                             entry_index,
    input  wire logic [6:0]                             entry_address,
    input  wire logic [4:0]                             entry_first_pixel,
    input  wire logic [4:0]                             entry_second_pixel,
    input  wire logic                                   bus_error,
    input  wire logic [7:0]                             read_byte,
    // result toward the output register
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output tsps_pkg::result_t                           res,
    // table memory
    output logic                                        ram_we,
    output logic [(NUM_DEVICES > 1 ? $clog2(NUM_DEVICES) : 1)-1:0] ram_waddr,
    output tsps_pkg::entry_t                            ram_wdata,
    output logic [(NUM_DEVICES > 1 ? $clog2(NUM_DEVICES) : 1)-1:0] ram_raddr,
    input  wire tsps_pkg::entry_t                       ram_rdata
);

    localparam int AW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int IDX_W = $clog2(NUM_DEVICES + 1);

    tsps_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  dev_idx_reg, dev_idx_next;
    logic [3:0]        retry_reg, retry_next;
    logic              read_phase_reg, read_phase_next;
    logic              busy_reg, busy_next;
    logic [31:0]       bitmap_reg, bitmap_next;
    tsps_pkg::entry_t  cur_reg, cur_next;
    tsps_pkg::result_t res_reg, res_next;
    logic [3:0]        max_retries_reg;
    logic [7:0]        sense_reg;

    logic              accept;
    logic              load_in_range;
    logic              load_hits_cur;
    logic              idx_past_end;
    logic [IDX_W-1:0]  dev_idx_inc;
    tsps_pkg::entry_t  load_entry;
    logic [31:0]       touch_bits;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == tsps_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == tsps_pkg::ST_EMIT);
    assign res       = res_reg;

    assign load_in_range = (32'(entry_index) < NUM_DEVICES);
    assign load_hits_cur = busy_reg && (32'(entry_index) == 32'(dev_idx_reg));
    assign idx_past_end  = (32'(dev_idx_reg) >= NUM_DEVICES);
    assign dev_idx_inc   = dev_idx_reg + IDX_W'(1);

    assign load_entry.address      = entry_address;
    assign load_entry.first_pixel  = entry_first_pixel;
    assign load_entry.second_pixel = entry_second_pixel;

    // pixel p lands at bit 31-p, which is the bitwise inverse of p
    always_comb
    begin
        touch_bits = 32'd0;
        if (read_byte[0])
        begin
            touch_bits[~cur_reg.first_pixel] = 1'b1;
        end
        if (read_byte[1])
        begin
            touch_bits[~cur_reg.second_pixel] = 1'b1;
        end
    end

    assign ram_we    = accept && (action == tsps_pkg::ACT_LOAD) && load_in_range;
    assign ram_waddr = AW'(entry_index);
    assign ram_wdata = load_entry;
    assign ram_raddr = dev_idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= tsps_pkg::MAX_RETRIES_RESET;
            sense_reg       <= tsps_pkg::SENSE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tsps_pkg::REG_MAX_RETRIES)
            begin
                max_retries_reg <= cfg_data[3:0];
            end
            else if (cfg_index == tsps_pkg::REG_SENSE)
            begin
                sense_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsps_pkg::ST_IDLE;
            dev_idx_reg    <= '0;
            retry_reg      <= 4'd0;
            read_phase_reg <= 1'b0;
            busy_reg       <= 1'b0;
            bitmap_reg     <= 32'd0;
        end
        else
        begin
            state_reg      <= state_next;
            dev_idx_reg    <= dev_idx_next;
            retry_reg      <= retry_next;
            read_phase_reg <= read_phase_next;
            busy_reg       <= busy_next;
            bitmap_reg     <= bitmap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        dev_idx_next    = dev_idx_reg;
        retry_next      = retry_reg;
        read_phase_next = read_phase_reg;
        busy_next       = busy_reg;
        bitmap_next     = bitmap_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;

        unique case (state_reg)
            tsps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        tsps_pkg::ACT_START:
                        begin
                            bitmap_next  = 32'd0;
                            busy_next    = 1'b1;
                            dev_idx_next = '0;
                            state_next   = tsps_pkg::ST_SEEK_RD;
                        end
                        tsps_pkg::ACT_LOAD:
                        begin
                            // a load of the device being polled takes effect at once
                            if (load_in_range && load_hits_cur)
                            begin
                                cur_next = load_entry;
                            end
                        end
                        tsps_pkg::ACT_XFER_DONE:
                        begin
                            if (busy_reg)
                            begin
                                res_next.command_valid   = 1'b1;
                                res_next.command_address = cur_reg.address;
                                res_next.scan_done       = 1'b0;
                                res_next.touch_bitmap    = bitmap_reg;
                                if (bus_error)
                                begin
                                    if (retry_reg < max_retries_reg)
                                    begin
                                        retry_next               = retry_reg + 4'd1;
                                        res_next.command_is_read = read_phase_reg;
                                        res_next.command_byte    =
                                            read_phase_reg ? 8'h00 : sense_reg;
                                        state_next               = tsps_pkg::ST_EMIT;
                                    end
                                    else
                                    begin
                                        dev_idx_next = dev_idx_inc;
                                        state_next   = tsps_pkg::ST_SEEK_RD;
                                    end
                                end
                                else if (!read_phase_reg)
                                begin
                                    read_phase_next          = 1'b1;
                                    res_next.command_is_read = 1'b1;
                                    res_next.command_byte    = 8'h00;
                                    state_next               = tsps_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    bitmap_next  = bitmap_reg | touch_bits;
                                    dev_idx_next = dev_idx_inc;
                                    state_next   = tsps_pkg::ST_SEEK_RD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            tsps_pkg::ST_SEEK_RD:
            begin
                if (idx_past_end)
                begin
                    dev_idx_next             = '0;
                    busy_next                = 1'b0;
                    retry_next               = 4'd0;
                    read_phase_next          = 1'b0;
                    res_next.command_valid   = 1'b0;
                    res_next.command_address = 7'd0;
                    res_next.command_is_read = 1'b0;
                    res_next.command_byte    = 8'h00;
                    res_next.scan_done       = 1'b1;
                    res_next.touch_bitmap    = bitmap_reg;
                    state_next               = tsps_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = tsps_pkg::ST_SEEK_CHK;
                end
            end

            tsps_pkg::ST_SEEK_CHK:
            begin
                if (ram_rdata.address != 7'd0)
                begin
                    cur_next                 = ram_rdata;
                    retry_next               = 4'd0;
                    read_phase_next          = 1'b0;
                    res_next.command_valid   = 1'b1;
                    res_next.command_address = ram_rdata.address;
                    res_next.command_is_read = 1'b0;
                    res_next.command_byte    = sense_reg;
                    res_next.scan_done       = 1'b0;
                    res_next.touch_bitmap    = bitmap_reg;
                    state_next               = tsps_pkg::ST_EMIT;
                end
                else
                begin
                    dev_idx_next = dev_idx_inc;
                    state_next   = tsps_pkg::ST_SEEK_RD;
                end
            end

            tsps_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = tsps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsps_pkg::ST_IDLE;
            end
        endcase
    end

    // the walk only ever checks data read in the cycle before
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsps_pkg::ST_SEEK_CHK |-> $past(state_reg) == tsps_pkg::ST_SEEK_RD)
        else $error("table check without a preceding read");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsps_pkg::ST_SEEK_RD || state_reg == tsps_pkg::ST_SEEK_CHK)
        |-> busy_reg)
        else $error("table walk while no scan is running");

    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsps_pkg::ST_SEEK_CHK |-> 32'(dev_idx_reg) < NUM_DEVICES)
        else $error("table read beyond the device count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsps_pkg::ST_EMIT && res_reg.scan_done)
        |-> (!busy_reg && retry_reg == 4'd0 && !read_phase_reg))
        else $error("scan done reported with scan state not cleared");

    a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == tsps_pkg::ST_IDLE)
        else $error("table write during a walk");

endmodule

`default_nettype wire

// ===== rtl/touch_sensor_poll_sequencer.sv =====
// A retry or write-to-read step registers its command in the result register, then the
// output register; a start or device change first walks the table (read, then check, per
// entry) and then registers the command, or a done when no present device remains.
// Items are taken only while idle: a load leaves the sequencer idle, while a start or a
// scan's transfer result holds it off until its result enters the output register.
// Reset: asynchronous, active low; scan idle, bitmap clear, max_retries 3, sense_register 0.
`timescale 1ns / 1ps
`default_nettype none

module touch_sensor_poll_sequencer #(
    parameter int NUM_DEVICES = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tsps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         action,
    input  wire logic [3:0]                         entry_index,
    input  wire logic [6:0]                         entry_address,
    input  wire logic [4:0]                         entry_first_pixel,
    input  wire logic [4:0]                         entry_second_pixel,
    input  wire logic                               bus_error,
    input  wire logic [7:0]                         read_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    command_valid,
    output logic [6:0]                              command_address,
    output logic                                    command_is_read,
    output logic [7:0]                              command_byte,
    output logic                                    scan_done,
    output logic [31:0]                             touch_bitmap
);

    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    logic              res_valid;
    logic              res_ready;
    tsps_pkg::result_t res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    tsps_pkg::entry_t  ram_wdata;
    tsps_pkg::entry_t  ram_rdata;

    logic              out_valid_reg, out_valid_next;
    tsps_pkg::result_t out_reg;

    tsps_ram #(
        .WIDTH (tsps_pkg::ENTRY_W),
        .DEPTH (NUM_DEVICES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsps_ctrl #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .entry_index        (entry_index),
        .entry_address      (entry_address),
        .entry_first_pixel  (entry_first_pixel),
        .entry_second_pixel (entry_second_pixel),
        .bus_error          (bus_error),
        .read_byte          (read_byte),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res                (res),
        .ram_we             (ram_we),
        .ram_waddr          (ram_waddr),
        .ram_wdata          (ram_wdata),
        .ram_raddr          (ram_raddr),
        .ram_rdata          (ram_rdata)
    );

    // output register: frees the sequencer while a result waits downstream
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign command_valid   = out_reg.command_valid;
    assign command_address = out_reg.command_address;
    assign command_is_read = out_reg.command_is_read;
    assign command_byte    = out_reg.command_byte;
    assign scan_done       = out_reg.scan_done;
    assign touch_bitmap    = out_reg.touch_bitmap;

    a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scan_done) |-> (!command_valid && command_address == 7'd0))
        else $error("done result carries a command");

    a_no_cmd_and_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_valid != scan_done))
        else $error("result is neither a command nor done");

    a_read_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_is_read) |-> (command_valid && command_byte == 8'h00))
        else $error("read command with a data byte");

endmodule

`default_nettype wire

// ===== dv/touch_sensor_poll_sequencer_tb.sv =====
// Self-checking testbench for touch_sensor_poll_sequencer: directed and random scans with
// a cycle-free predictor in a small scoreboard class. Depends on rtl/tsps_pkg.sv and the RTL.
`timescale 1ns / 1ps

module touch_sensor_poll_sequencer_tb;

    localparam int NUM_DEV        = 16;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 64;     // covers a full table walk
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int ITEMS_PER_PHASE = 130;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] entry_idx;
        logic [6:0] entry_addr;
        logic [4:0] first_px;
        logic [4:0] second_px;
        logic       bus_err;
        logic [7:0] rd_byte;
    } poll_event_t;

    class touch_scoreboard;
        tsps_pkg::entry_t  slots[NUM_DEV];
        logic [4:0]        cur_dev;
        logic [3:0]        tries;
        logic              reading;
        logic              busy;
        logic [31:0]       touches;
        logic [3:0]        retry_limit;
        logic [7:0]        pointer_byte;
        tsps_pkg::result_t pending_q[$];
        int                errors;
        int                inputs_seen;
        int                results_seen;
        int                scans_done;
        int                retries_seen;
        int                skips_seen;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            cur_dev      = '0;
            tries        = '0;
            reading      = 1'b0;
            busy         = 1'b0;
            touches      = '0;
            retry_limit  = tsps_pkg::MAX_RETRIES_RESET;
            pointer_byte = tsps_pkg::SENSE_RESET;
            errors       = 0;
            inputs_seen  = 0;
            results_seen = 0;
            scans_done   = 0;
            retries_seen = 0;
            skips_seen   = 0;
        endfunction

        function void note_config(logic [tsps_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
            if (idx == tsps_pkg::REG_MAX_RETRIES)
                retry_limit = data[3:0];
            else if (idx == tsps_pkg::REG_SENSE)
                pointer_byte = data;
        endfunction

        function tsps_pkg::result_t command_result(logic rd);
            tsps_pkg::result_t r;
            r.command_valid   = 1'b1;
            r.command_address = slots[cur_dev].address;
            r.command_is_read = rd;
            r.command_byte    = rd ? 8'h00 : pointer_byte;
            r.scan_done       = 1'b0;
            r.touch_bitmap    = touches;
            return r;
        endfunction

        // Walk to the next present device; either start its pointer write or finish.
        function tsps_pkg::result_t advance_to(int unsigned from);
            int unsigned       k;
            tsps_pkg::result_t r;
            k = from;
            while (k < NUM_DEV && slots[k].address == 7'd0)
                k++;
            tries   = '0;
            reading = 1'b0;
            if (k >= NUM_DEV)
            begin
                cur_dev = '0;
                busy    = 1'b0;
                r       = '0;
                r.scan_done    = 1'b1;
                r.touch_bitmap = touches;
            end
            else
            begin
                cur_dev = k[4:0];
                r = command_result(1'b0);
            end
            return r;
        endfunction

        function void note_input(poll_event_t ev);
            inputs_seen++;
            case (ev.action)
                tsps_pkg::ACT_START:
                begin
                    touches = '0;
                    busy    = 1'b1;
                    pending_q.push_back(advance_to(0));
                end
                tsps_pkg::ACT_LOAD:
                begin
                    slots[ev.entry_idx] = '{second_pixel: ev.second_px,
                                            first_pixel: ev.first_px,
                                            address: ev.entry_addr};
                end
                tsps_pkg::ACT_XFER_DONE:
                begin
                    if (busy)
                    begin
                        if (ev.bus_err)
                        begin
                            if (tries < retry_limit)
                            begin
                                tries++;
                                retries_seen++;
                                pending_q.push_back(command_result(reading));
                            end
                            else
                            begin
                                skips_seen++;
                                pending_q.push_back(advance_to(cur_dev + 1));
                            end
                        end
                        else if (!reading)
                        begin
                            reading = 1'b1;
                            pending_q.push_back(command_result(1'b1));
                        end
                        else
                        begin
                            if (ev.rd_byte[0])
                                touches[5'd31 - slots[cur_dev].first_pixel] = 1'b1;
                            if (ev.rd_byte[1])
                                touches[5'd31 - slots[cur_dev].second_pixel] = 1'b1;
                            pending_q.push_back(advance_to(cur_dev + 1));
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $realtime, name, want, got);
            end
        endfunction

        function void check(tsps_pkg::result_t got);
            tsps_pkg::result_t want;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                         $realtime, got);
                return;
            end
            want = pending_q.pop_front();
            if (want.scan_done)
                scans_done++;
            compare_field("command_valid",   32'(want.command_valid),   32'(got.command_valid));
            compare_field("command_address", 32'(want.command_address),
                          32'(got.command_address));
            compare_field("command_is_read", 32'(want.command_is_read),
                          32'(got.command_is_read));
            compare_field("command_byte",    32'(want.command_byte),    32'(got.command_byte));
            compare_field("scan_done",       32'(want.scan_done),       32'(got.scan_done));
            compare_field("touch_bitmap",    want.touch_bitmap,         got.touch_bitmap);
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tsps_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tsps_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [1:0]                       action;
    logic [3:0]                       entry_index;
    logic [6:0]                       entry_address;
    logic [4:0]                       entry_first_pixel;
    logic [4:0]                       entry_second_pixel;
    logic                             bus_error;
    logic [7:0]                       read_byte;
    logic                             out_valid;
    logic                             out_ready;
    logic                             command_valid;
    logic [6:0]                       command_address;
    logic                             command_is_read;
    logic [7:0]                       command_byte;
    logic                             scan_done;
    logic [31:0]                      touch_bitmap;

    touch_scoreboard sb = new();
    logic            steady = 1'b0;      // both sides run without gaps
    logic            hold_request = 1'b0;

    touch_sensor_poll_sequencer #(.NUM_DEVICES(NUM_DEV)) DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .entry_index        (entry_index),
        .entry_address      (entry_address),
        .entry_first_pixel  (entry_first_pixel),
        .entry_second_pixel (entry_second_pixel),
        .bus_error          (bus_error),
        .read_byte          (read_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .command_valid      (command_valid),
        .command_address    (command_address),
        .command_is_read    (command_is_read),
        .command_byte       (command_byte),
        .scan_done          (scan_done),
        .touch_bitmap       (touch_bitmap)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check('{command_valid: command_valid, command_address: command_address,
                       command_is_read: command_is_read, command_byte: command_byte,
                       scan_done: scan_done, touch_bitmap: touch_bitmap});
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 12);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // Watchdog: cycles with no transaction on any channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic poll_event_t rand_event();
        poll_event_t ev;
        ev.action     = 2'($urandom_range(0, 3));
        ev.entry_idx  = 4'($urandom_range(0, 15));
        ev.entry_addr = 7'($urandom_range(0, 127));
        ev.first_px   = 5'($urandom_range(0, 31));
        ev.second_px  = 5'($urandom_range(0, 31));
        ev.bus_err    = 1'($urandom_range(0, 1));
        ev.rd_byte    = 8'($urandom_range(0, 255));
        return ev;
    endfunction

    task automatic send_event(input poll_event_t ev);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        action             <= ev.action;
        entry_index        <= ev.entry_idx;
        entry_address      <= ev.entry_addr;
        entry_first_pixel  <= ev.first_px;
        entry_second_pixel <= ev.second_px;
        bus_error          <= ev.bus_err;
        read_byte          <= ev.rd_byte;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(ev);
    endtask

    task automatic send_load(input logic [3:0] idx, input logic [6:0] addr,
                             input logic [4:0] px0, input logic [4:0] px1);
        poll_event_t ev;
        ev = rand_event();
        ev.action     = tsps_pkg::ACT_LOAD;
        ev.entry_idx  = idx;
        ev.entry_addr = addr;
        ev.first_px   = px0;
        ev.second_px  = px1;
        send_event(ev);
    endtask

    task automatic send_xfer(input logic err, input logic [7:0] data);
        poll_event_t ev;
        ev = rand_event();
        ev.action  = tsps_pkg::ACT_XFER_DONE;
        ev.bus_err = err;
        ev.rd_byte = data;
        send_event(ev);
    endtask

    task automatic send_action(input logic [1:0] act);
        poll_event_t ev;
        ev = rand_event();
        ev.action = act;
        send_event(ev);
    endtask

    task automatic program_regs(input logic [3:0] retries, input logic [7:0] sense);
        cfg_valid <= 1'b1;
        cfg_index <= tsps_pkg::REG_MAX_RETRIES;
        cfg_data  <= {4'h0, retries};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(tsps_pkg::REG_MAX_RETRIES, {4'h0, retries});
        cfg_index <= tsps_pkg::REG_SENSE;
        cfg_data  <= sense;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(tsps_pkg::REG_SENSE, sense);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain all expected results, then let any table walk finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        send_load(4'd0, 7'd0, 5'd31, 5'd31);
        for (int i = 1; i < NUM_DEV; i++)
            send_load(4'(i), 7'd0, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        send_action(tsps_pkg::ACT_START);    // empty table: done at once
        send_xfer(1'b1, 8'hFF);              // idle, ignored
        send_action(ACT_UNUSED);
        send_load(4'd15, 7'd127, 5'd0, 5'd31);
        send_load(4'd0, 7'd1, 5'd31, 5'd0);
        send_action(tsps_pkg::ACT_START);
        send_xfer(1'b1, 8'h00);              // retry the pointer write
        send_xfer(1'b0, 8'h00);
        send_action(tsps_pkg::ACT_START);    // restart mid-scan
        send_xfer(1'b0, 8'h00);
        send_load(4'd7, 7'h55, 5'd16, 5'd15); // lands ahead of the scan
        send_xfer(1'b0, 8'h03);
        repeat (4) send_xfer(1'b1, 8'hFF);   // retries run out, device skipped
        send_xfer(1'b0, 8'h00);
        send_xfer(1'b0, 8'hFE);
    endtask

    task automatic run_random(input int target, input int err_pct);
        int          counted;
        int          sent;
        int          roll;
        int          stuck;
        logic        ignored;
        poll_event_t ev;
        counted = 0;
        sent    = 0;
        stuck   = 0;
        while (counted < target)
        begin
            if (sent % 32 == 0)
                steady = ($urandom_range(0, 3) == 0);
            ev   = rand_event();
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                if (sb.busy)
                begin
                    ev.action = tsps_pkg::ACT_XFER_DONE;
                    // occasional dead device: a run of errors, at times long enough to skip it
                    if (stuck == 0 && $urandom_range(0, 24) == 0)
                        stuck = $urandom_range(1, 17);
                    if (stuck > 0)
                    begin
                        ev.bus_err = 1'b1;
                        stuck--;
                    end
                    else
                        ev.bus_err = ($urandom_range(0, 99) < err_pct);
                end
                else
                    ev.action = tsps_pkg::ACT_START;
            end
            else if (roll < 87)
            begin
                ev.action = tsps_pkg::ACT_LOAD;
                if ($urandom_range(0, 99) < 40)
                    ev.entry_addr = '0;
            end
            else if (roll < 92)
                ev.action = ACT_UNUSED;
            else if (roll < 96)
                ev.action = tsps_pkg::ACT_XFER_DONE;
            else
                ev.action = tsps_pkg::ACT_START;
            ignored = (ev.action == ACT_UNUSED) ||
                      (ev.action == tsps_pkg::ACT_XFER_DONE && !sb.busy);
            send_event(ev);
            sent++;
            if (!ignored)
                counted++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        action             <= '0;
        entry_index        <= '0;
        entry_address      <= '0;
        entry_first_pixel  <= '0;
        entry_second_pixel <= '0;
        bus_error          <= 1'b0;
        read_byte          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph)
                0: program_regs(4'd0, 8'hFF);
                1: program_regs(4'd15, 8'h00);
                2: program_regs(4'd1, 8'hA5);
                default: program_regs(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            endcase
            if (ph == 1)
                hold_request = 1'b1;
            run_random(ITEMS_PER_PHASE, (ph == 1) ? 45 : 20);
        end
        drain();

        $display("run covered %0d input transactions and %0d results, %0d completed scans",
                 sb.inputs_seen, sb.results_seen, sb.scans_done);
        $display("bus errors retried %0d times, %0d devices skipped after retries ran out",
                 sb.retries_seen, sb.skips_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
